[hw/rtl/btcp_pkg.sv]
// Shared types and constants of the binary tile code packer.
// Used by every module of the block but btcp_ram and btcp_checker; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package btcp_pkg;

  // Field and counter widths.
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned CODE_W   = 25;
  localparam int unsigned CODE_TOP = 24;
  localparam int unsigned TROW_W   = 10;
  localparam int unsigned TCOL_W   = 8;
  localparam int unsigned COL_W    = 11;
  localparam int unsigned ROW_W    = 12;
  localparam int unsigned HEIGHT_W = 13;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned BITPOS_W = 5;

  // Pixel value that sets its code bit.
  localparam logic [PIX_W-1:0] PIX_ONE = 8'd1;

  // Result queue sizing.
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PW    = 2;
  localparam int unsigned OQ_CW    = 3;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Decoded position of one pixel.
  typedef struct packed {
    logic                in_tile;
    logic                first;
    logic                last_px;
    logic                frame_last;
    logic [BITPOS_W-1:0] bitpos;
    logic [COL_W-1:0]    tc;
    logic [TROW_W-1:0]   tr;
  } pos_t;

  // One finished tile.
  typedef struct packed {
    logic [TCOL_W-1:0] tile_col;
    logic [TROW_W-1:0] tile_row;
    logic [CODE_W-1:0] tile_code;
    logic              frame_last;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/btcp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module btcp_ram #(
  parameter int unsigned WIDTH = 25,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AddrW-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [AddrW-1:0]         raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; returns the old contents on a same-address write.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/btcp_pos.sv]
// Raster position tracker: pixel and tile counters, tile membership and bit index.
// Depends on btcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btcp_pos
  import btcp_pkg::*;
#(
  parameter int unsigned BLOCK         = 5,
  parameter int unsigned MAX_TILE_COLS = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic                frame_start_i,
  input  wire logic [COL_W-1:0]    image_width_i,
  input  wire logic [HEIGHT_W-1:0] image_height_i,
  output pos_t                     pos_o
);

  localparam int unsigned LcW = (BLOCK > 1) ? $clog2(BLOCK) : 1;
  localparam logic [LcW-1:0] LcMax = LcW'(BLOCK - 1);

  // Counter registers: pixel column/row plus their tile decomposition.
  logic [COL_W-1:0]  col_q, col_d, col_c;
  logic [LcW-1:0]    lc_q, lc_d, lc_c;
  logic [COL_W-1:0]  tc_q, tc_d, tc_c;
  logic [COL_W-1:0]  tsc_q, tsc_d, tsc_c;
  logic [ROW_W-1:0]  row_q, row_d, row_c;
  logic [LcW-1:0]    lr_q, lr_d, lr_c;
  logic [TROW_W-1:0] tr_q, tr_d, tr_c;
  logic [ROW_W-1:0]  tsr_q, tsr_d, tsr_c;

  logic              in_x, in_y, last_x, last_y, col_wrap, row_wrap;
  logic [BITPOS_W-1:0] bit_idx;

  // A frame start restarts the raster at the top-left corner.
  always_comb begin
    col_c = frame_start_i ? '0 : col_q;
    lc_c  = frame_start_i ? '0 : lc_q;
    tc_c  = frame_start_i ? '0 : tc_q;
    tsc_c = frame_start_i ? '0 : tsc_q;
    row_c = frame_start_i ? '0 : row_q;
    lr_c  = frame_start_i ? '0 : lr_q;
    tr_c  = frame_start_i ? '0 : tr_q;
    tsr_c = frame_start_i ? '0 : tsr_q;
  end

  // Tile membership and last-tile tests against the current image size.
  always_comb begin
    in_x = (({1'b0, tsc_c} + (COL_W+1)'(BLOCK)) <= {1'b0, image_width_i}) &&
           ({1'b0, tc_c} < (COL_W+1)'(MAX_TILE_COLS));
    last_x = (({1'b0, tsc_c} + (COL_W+1)'(2 * BLOCK)) > {1'b0, image_width_i}) ||
             ({1'b0, tc_c} == (COL_W+1)'(MAX_TILE_COLS - 1));
    in_y = (({1'b0, tsr_c} + HEIGHT_W'(BLOCK)) <= image_height_i);
    last_y = (({1'b0, tsr_c} + HEIGHT_W'(2 * BLOCK)) > image_height_i);
    bit_idx = BITPOS_W'(lr_c) * BITPOS_W'(BLOCK) + BITPOS_W'(lc_c);
  end

  always_comb begin
    pos_o.in_tile    = in_x && in_y;
    pos_o.first      = (lr_c == '0) && (lc_c == '0);
    pos_o.last_px    = (lr_c == LcMax) && (lc_c == LcMax);
    pos_o.frame_last = last_x && last_y;
    pos_o.bitpos     = BITPOS_W'(CODE_TOP) - bit_idx;
    pos_o.tc         = tc_c;
    pos_o.tr         = tr_c;
  end

  // Advance to the next raster position.
  always_comb begin
    col_wrap = (({1'b0, col_c} + (COL_W+1)'(1)) >= {1'b0, image_width_i}) || (col_c == '1);
    row_wrap = (({1'b0, row_c} + HEIGHT_W'(1)) >= image_height_i) || (row_c == '1);

    col_d = col_c + COL_W'(1);
    lc_d  = lc_c + LcW'(1);
    tc_d  = tc_c;
    tsc_d = tsc_c;
    if (lc_c == LcMax) begin
      lc_d  = '0;
      tc_d  = tc_c + COL_W'(1);
      tsc_d = tsc_c + COL_W'(BLOCK);
    end

    row_d = row_c;
    lr_d  = lr_c;
    tr_d  = tr_c;
    tsr_d = tsr_c;
    if (col_wrap) begin
      col_d = '0;
      lc_d  = '0;
      tc_d  = '0;
      tsc_d = '0;
      if (row_wrap) begin
        row_d = '0;
        lr_d  = '0;
        tr_d  = '0;
        tsr_d = '0;
      end else begin
        row_d = row_c + ROW_W'(1);
        lr_d  = lr_c + LcW'(1);
        if (lr_c == LcMax) begin
          lr_d  = '0;
          tr_d  = tr_c + TROW_W'(1);
          tsr_d = tsr_c + ROW_W'(BLOCK);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      lc_q  <= '0;
      tc_q  <= '0;
      tsc_q <= '0;
      row_q <= '0;
      lr_q  <= '0;
      tr_q  <= '0;
      tsr_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      lc_q  <= lc_d;
      tc_q  <= tc_d;
      tsc_q <= tsc_d;
      row_q <= row_d;
      lr_q  <= lr_d;
      tr_q  <= tr_d;
      tsr_q <= tsr_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/btcp_merge.sv]
// Partial code store and bit merge: read-modify-write of one tile column per pixel.
// Depends on btcp_pkg and btcp_ram.
`timescale 1ns / 1ps
`default_nettype none

module btcp_merge
  import btcp_pkg::*;
#(
  parameter int unsigned MAX_TILE_COLS = 256
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [PIX_W-1:0] pixel_value_i,
  input  pos_t                  pos_i,
  output logic                  busy_o,
  output logic                  res_valid_o,
  output result_t               res_o
);

  localparam int unsigned AddrW = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;

  // Merge stage registers.
  logic              b_valid_q;
  pos_t              b_pos_q;
  logic              b_bit_q;

  // Last write, forwarded to a back-to-back read of the same entry.
  logic              fwd_valid_q;
  logic [AddrW-1:0]  fwd_addr_q;
  logic [CODE_W-1:0] fwd_code_q;

  logic [CODE_W-1:0] rdata;
  logic [CODE_W-1:0] prev_code, code;
  logic [AddrW-1:0]  b_addr;
  logic              we;

  btcp_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAX_TILE_COLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (b_addr),
    .wdata_i (code),
    .re_i    (accept_i),
    .raddr_i (pos_i.tc[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      b_valid_q   <= accept_i;
      fwd_valid_q <= we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      b_pos_q <= pos_i;
      b_bit_q <= (pixel_value_i == PIX_ONE);
    end
    fwd_addr_q <= b_addr;
    fwd_code_q <= code;
  end

  // Merge the pixel bit into the tile's partial code.
  always_comb begin
    b_addr    = b_pos_q.tc[AddrW-1:0];
    prev_code = (fwd_valid_q && (fwd_addr_q == b_addr)) ? fwd_code_q : rdata;
    code      = (b_pos_q.first ? '0 : prev_code) |
                (CODE_W'(b_bit_q) << b_pos_q.bitpos);
    we        = b_valid_q && b_pos_q.in_tile;
  end

  assign busy_o             = b_valid_q;
  assign res_valid_o        = we && b_pos_q.last_px;
  assign res_o.tile_code    = code;
  assign res_o.tile_row     = b_pos_q.tr;
  assign res_o.tile_col     = b_pos_q.tc[TCOL_W-1:0];
  assign res_o.frame_last   = b_pos_q.frame_last;

endmodule

`default_nettype wire

[hw/rtl/btcp_outq.sv]
// Small result queue feeding the output stream, with an input credit check.
// Depends on btcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btcp_outq
  import btcp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  result_t      push_data_i,
  input  wire logic    pend_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      out_data_o
);

  result_t            q_mem_q [OQ_DEPTH];
  logic [OQ_PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [OQ_CW-1:0]   count_q, count_d;
  logic               pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = q_mem_q[rd_ptr_q];

  // Room for every item already past the input, plus one more.
  assign in_ready_o  = ((count_q + OQ_CW'(pend_i)) < OQ_CW'(OQ_DEPTH));

  always_comb begin
    count_d = count_q + OQ_CW'(push_i) - OQ_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OQ_PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OQ_PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/binary_tile_code_packer_top.sv]
// Top level of the binary tile code packer: configuration registers and stream ports.
// Depends on btcp_pkg, btcp_pos, btcp_merge and btcp_outq.
//
//   Channel   Direction  Handshake                 Contents
//   s_axis    in         tvalid/tready             tdata: pixel_value; tuser: frame_start
//   m_axis    out        tvalid/tready             tdata: tile_code, tile_row, tile_col;
//                                                  tlast: frame_last
//   cfg       in         cfg_we_i (no wait)        cfg_idx_i selects, cfg_wdata_i data
//
// One pixel is taken every cycle while the result queue has room. A tile code passes
// the partial code RAM read and the merge after its last pixel, then the result queue.
// The partial code RAM needs no clearing pass; each entry is rebuilt by the first
// pixel of its tile. Reset clears the counters and the result queue at once.
// The input stalls only when the four-entry result queue backs up.
`timescale 1ns / 1ps
`default_nettype none

module binary_tile_code_packer_top
  import btcp_pkg::*;
#(
  parameter int unsigned BLOCK         = 5,
  parameter int unsigned MAX_TILE_COLS = 256
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Pixel input.
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,   // [7:0] pixel_value
  input  wire logic             s_axis_tuser,   // [0] frame_start
  // Tile code output.
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [47:0]           m_axis_tdata,   // [24:0] tile_code, [34:25] tile_row,
                                                // [42:35] tile_col, [47:43] zero
  output logic                  m_axis_tlast,   // frame_last
  // Configuration writes.
  input  wire logic             cfg_we_i,
  input  wire logic [0:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i
);

  localparam logic [COL_W-1:0]    WidthRst  = COL_W'(640);
  localparam logic [HEIGHT_W-1:0] HeightRst = HEIGHT_W'(480);

  logic [COL_W-1:0]    image_width_q;
  logic [HEIGHT_W-1:0] image_height_q;
  logic                accept;
  pos_t                pos;
  logic                busy, res_valid;
  result_t             res, out_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= WidthRst;
      image_height_q <= HeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata_i[COL_W-1:0];
        REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  btcp_pos #(
    .BLOCK         (BLOCK),
    .MAX_TILE_COLS (MAX_TILE_COLS)
  ) u_pos (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .frame_start_i  (s_axis_tuser),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .pos_o          (pos)
  );

  btcp_merge #(
    .MAX_TILE_COLS (MAX_TILE_COLS)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .pixel_value_i (s_axis_tdata),
    .pos_i         (pos),
    .busy_o        (busy),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  btcp_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pend_i      (busy),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  // Output packing.
  assign m_axis_tdata = {5'b0, out_res.tile_col, out_res.tile_row, out_res.tile_code};
  assign m_axis_tlast = out_res.frame_last;

endmodule

`default_nettype wire

[hw/rtl/btcp_checker.sv]
// Port-level checks of the binary tile code packer, bound to the top level.
// Depends on binary_tile_code_packer_top for the bind target.
`timescale 1ns / 1ps
`default_nettype none

module btcp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // The queue is empty in the cycle after reset is seen.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A new result follows an input transfer, through the merge stage and the result queue.
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching input transfer");

  // The input is held off only while results are waiting.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind binary_tile_code_packer_top btcp_checker u_btcp_checker (.*);

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for binary_tile_code_packer_top.
// Depends on btcp_pkg and the packer RTL; streams pixel frames with random gaps on both
// sides and checks every tile code transfer against a predictor of the packer.
`timescale 1ns / 1ps

module tb_top;
  import btcp_pkg::*;

  localparam int unsigned BLK        = 5;
  localparam int unsigned TILE_COLS  = 256;
  localparam int unsigned DRAIN_CYC  = 8;
  localparam int unsigned NUM_ITEMS  = 1200;
  localparam int unsigned DIR_ROWS   = 25;

  // One row of the directed stimulus table.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             start;
    logic             typed;
    result_t          want;
  } dir_row_t;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             s_valid   = 1'b0;
  logic             s_ready;
  logic [7:0]       s_data    = '0;
  logic             s_user    = 1'b0;
  logic             m_valid;
  logic             m_ready   = 1'b0;
  logic [47:0]      m_data;
  logic             m_last;
  logic             cfg_we    = 1'b0;
  cfg_reg_e         cfg_idx   = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Predictor state: geometry registers, raster position and per-column partial codes.
  logic [COL_W-1:0]    geo_width  = COL_W'(640);
  logic [HEIGHT_W-1:0] geo_height = HEIGHT_W'(480);
  logic [COL_W-1:0]    pos_col    = '0;
  logic [ROW_W-1:0]    pos_row    = '0;
  logic [CODE_W-1:0]   part_code [TILE_COLS];
  result_t             pending_tiles [$];

  int unsigned mismatch_cnt = 0;
  int unsigned item_cnt     = 0;
  bit          src_calm     = 1'b0;
  bit          snk_calm     = 1'b0;
  int unsigned snk_wait     = 0;
  dir_row_t    dir_tab [DIR_ROWS];

  binary_tile_code_packer_top #(
    .BLOCK        (BLK),
    .MAX_TILE_COLS(TILE_COLS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tlast (m_last),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle cycles before the next transfer; none while a side runs calm.
  function automatic int unsigned pick_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Mostly ones and zeros, so tiles carry real content, with some arbitrary bytes.
  function automatic logic [PIX_W-1:0] rand_pixel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return PIX_ONE;
    if (r < 7) return '0;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // Applies one pixel to the predictor and advances the raster position.
  task automatic pack_pixel(input logic [PIX_W-1:0] pix, input logic start,
                            output bit hit, output result_t res);
    int unsigned tiles_x, tiles_y, tc, tr, lc, lr, nc, nr;
    logic [CODE_W-1:0] code;
    bit in_tile;
    hit = 1'b0;
    res = '0;
    if (start) begin
      pos_col = '0;
      pos_row = '0;
    end
    tiles_x = geo_width / BLK;
    if (tiles_x > TILE_COLS) tiles_x = TILE_COLS;
    tiles_y = geo_height / BLK;
    tc = pos_col / BLK;
    tr = pos_row / BLK;
    in_tile = (tc < tiles_x) && (tr < tiles_y);
    if (in_tile) begin
      lc = pos_col % BLK;
      lr = pos_row % BLK;
      // The first pixel of a tile starts a fresh code.
      code = (lr == 0 && lc == 0) ? '0 : part_code[tc];
      if (pix == PIX_ONE) code[CODE_TOP - (lr * BLK + lc)] = 1'b1;
      part_code[tc] = code;
      if (lr == BLK - 1 && lc == BLK - 1) begin
        hit            = 1'b1;
        res.tile_code  = code;
        res.tile_row   = TROW_W'(tr);
        res.tile_col   = TCOL_W'(tc);
        res.frame_last = (tr == tiles_y - 1) && (tc == tiles_x - 1);
      end
    end
    // Column wraps at the width, row at the height, each also past its counter range.
    nc = pos_col + 1;
    if (nc >= geo_width || nc > (1 << COL_W) - 1) begin
      nc = 0;
      nr = pos_row + 1;
      if (nr >= geo_height || nr > (1 << ROW_W) - 1) nr = 0;
      pos_row = ROW_W'(nr);
    end
    pos_col = COL_W'(nc);
  endtask

  // Drives one pixel transfer and records the tile code it completes, if any.
  task automatic feed_pixel(input logic [PIX_W-1:0] pix, input logic start,
                            input bit typed, input result_t want);
    int unsigned gap;
    bit          hit;
    result_t     res;
    if ($urandom_range(0, 63) == 0) src_calm = ~src_calm;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= pix;
    s_user  <= start;
    do @(posedge clk_i); while (!s_ready);
    pack_pixel(pix, start, hit, res);
    item_cnt++;
    if (hit) pending_tiles.push_back(typed ? want : res);
  endtask

  // Sends a run of random pixels; stray_pm is the per-mille rate of stray frame starts.
  task automatic send_run(input int unsigned n, input bit with_start,
                          input int unsigned stray_pm);
    logic start;
    for (int unsigned i = 0; i < n; i++) begin
      start = (i == 0) ? with_start : ($urandom_range(0, 999) < stray_pm);
      feed_pixel(rand_pixel(), start, 1'b0, '0);
    end
  endtask

  // Rewrites both geometry registers once the packer has gone idle.
  task automatic set_geometry(input int unsigned w, input int unsigned h);
    s_valid <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    // Bits above the width register carry junk that must be dropped.
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_IMAGE_WIDTH;
    cfg_wdata <= {2'($urandom_range(0, 3)), COL_W'(w)};
    @(posedge clk_i);
    geo_width  = COL_W'(w);
    cfg_idx   <= REG_IMAGE_HEIGHT;
    cfg_wdata <= HEIGHT_W'(h);
    @(posedge clk_i);
    geo_height = HEIGHT_W'(h);
    cfg_we    <= 1'b0;
  endtask

  // Output side: random back-pressure and field-by-field checking of each transfer.
  always @(posedge clk_i) begin
    result_t exp_tile;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        if (pending_tiles.size() == 0) begin
          $error("unexpected tile code transfer: tdata %h", m_data);
          mismatch_cnt++;
        end else begin
          exp_tile = pending_tiles.pop_front();
          if (m_data[CODE_W-1:0] !== exp_tile.tile_code) begin
            $error("tile_code: expected %h, actual %h", exp_tile.tile_code,
                   m_data[CODE_W-1:0]);
            mismatch_cnt++;
          end
          if (m_data[CODE_W +: TROW_W] !== exp_tile.tile_row) begin
            $error("tile_row: expected %0d, actual %0d", exp_tile.tile_row,
                   m_data[CODE_W +: TROW_W]);
            mismatch_cnt++;
          end
          if (m_data[CODE_W+TROW_W +: TCOL_W] !== exp_tile.tile_col) begin
            $error("tile_col: expected %0d, actual %0d", exp_tile.tile_col,
                   m_data[CODE_W+TROW_W +: TCOL_W]);
            mismatch_cnt++;
          end
          if (m_data[47:CODE_W+TROW_W+TCOL_W] !== '0) begin
            $error("tdata padding: expected 0, actual %h", m_data[47:CODE_W+TROW_W+TCOL_W]);
            mismatch_cnt++;
          end
          if (m_last !== exp_tile.frame_last) begin
            $error("frame_last: expected %b, actual %b", exp_tile.frame_last, m_last);
            mismatch_cnt++;
          end
        end
        if ($urandom_range(0, 39) == 0) snk_calm = ~snk_calm;
        snk_wait = pick_gap(snk_calm);
      end
      if (snk_wait > 0) begin
        snk_wait--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    int unsigned w, h, n, cut;
    // One 5x5 frame: the first pixel sets bit 24, bytes other than one leave their bits
    // clear, and the last pixel finishes the only tile of the frame.
    dir_tab = '{
      '{8'd1,   1'b1, 1'b0, '0},
      '{8'd255, 1'b0, 1'b0, '0},
      '{8'd0,   1'b0, 1'b0, '0},
      '{8'd2,   1'b0, 1'b0, '0},
      '{8'd128, 1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b1, '{8'd0, 10'd0, 25'h10F_FFFF, 1'b1}}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A few pixels under the reset geometry, then the directed frame.
    send_run(3, 1'b1, 0);
    set_geometry(BLK, BLK);
    for (int i = 0; i < DIR_ROWS; i++) begin
      feed_pixel(dir_tab[i].pix, dir_tab[i].start, dir_tab[i].typed, dir_tab[i].want);
    end

    // Geometries with no whole tile: zero width, zero height, register extremes.
    set_geometry(0, BLK);
    send_run(30, 1'b1, 0);
    set_geometry(2 * BLK, 0);
    send_run(30, 1'b1, 0);
    set_geometry(1, 4096);
    send_run(40, 1'b1, 0);
    set_geometry(1280, 1);
    send_run(40, 1'b1, 0);

    // Frame restarted in the middle of a tile row.
    set_geometry(2 * BLK, 2 * BLK);
    send_run(37, 1'b1, 0);
    send_run(100, 1'b1, 0);

    // Width shrinks mid-frame with the column already past the new limit.
    set_geometry(3 * BLK, 2 * BLK);
    send_run(40, 1'b1, 0);
    set_geometry(2 * BLK, 2 * BLK);
    send_run(120, 1'b0, 0);

    // Random small frames: mostly whole frames, some broken, noisy or reconfigured.
    while (item_cnt < NUM_ITEMS) begin
      w = $urandom_range(BLK, 4 * BLK + 4);
      h = $urandom_range(BLK, 4 * BLK + 4);
      if ($urandom_range(0, 15) == 0) w = $urandom_range(0, BLK - 1);
      if ($urandom_range(0, 15) == 0) h = $urandom_range(0, BLK - 1);
      set_geometry(w, h);
      n = w * h + BLK;
      case ($urandom_range(0, 9))
        7: begin
          cut = $urandom_range(1, n);
          send_run(cut, 1'b1, 0);
          send_run(n, 1'b1, 0);
        end
        8: send_run(n, 1'b1, 20);
        9: begin
          cut = $urandom_range(1, n);
          send_run(cut, 1'b1, 0);
          set_geometry($urandom_range(BLK, 4 * BLK + 4), $urandom_range(BLK, 4 * BLK + 4));
          send_run(n, 1'b0, 0);
        end
        default: send_run(n, 1'b1, 0);
      endcase
    end

    // Let the last tile codes drain, then give late transfers a chance to show up.
    s_valid <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk_i);
    repeat (4 * DRAIN_CYC) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/btcp_pkg.sv
hw/rtl/btcp_ram.sv
hw/rtl/btcp_pos.sv
hw/rtl/btcp_merge.sv
hw/rtl/btcp_outq.sv
hw/rtl/binary_tile_code_packer_top.sv
hw/rtl/btcp_checker.sv
dv/tb_top.sv
